// File: rtl/qpct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpct_pkg
// Shared types and constants for the quadratic-probe credential table.
// ----------------------------------------------------------------------------
package qpct_pkg;

    // Default table geometry
    localparam int TABLE_SIZE_DEF  = 64;
    localparam int LOGIN_CHARS_DEF = 8;

    // Field widths
    localparam int KEY_W    = 64;
    localparam int DH_W     = 64;
    localparam int DM_W     = 64;
    localparam int DL_W     = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int SUM_W    = 11;    // sum of eight bytes, at most 2040

    // Reciprocal of ten for sums below 2048: q = (sum * 6554) >> 16
    localparam int RECIP10_W     = 13;
    localparam int RECIP10_SHIFT = 16;
    localparam logic [RECIP10_W-1:0] RECIP10 = 13'd6554;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

    // Commands
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;

    // One table entry as kept in memory
    typedef struct packed {
        logic            used;
        logic [DL_W-1:0] digest_low;
        logic [DM_W-1:0] digest_mid;
        logic [DH_W-1:0] digest_high;
        logic [KEY_W-1:0] login;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage : qpct_pkg
`default_nettype wire

// File: rtl/qpct_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpct_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qpct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule : qpct_ram
`default_nettype wire

// File: rtl/quadratic_probe_credential_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_credential_table_top
// Steps: accept, quotient, remainder, home slot, p probes (p = 1..TABLE_SIZE), done, output.
// One word at a time: ready only when idle; one table slot is read per probe cycle.
// Reset: synchronous; then a clearing pass over every slot, input not ready.
// Open-addressing login/digest table with quadratic probing over one RAM port.
// ----------------------------------------------------------------------------
module quadratic_probe_credential_table_top
    import qpct_pkg::*;
#(
    parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
    parameter int LOGIN_CHARS = LOGIN_CHARS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input words
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // [63:0] login_key, [127:64] digest_high, [191:128] digest_mid,
    // [223:192] digest_low
    input  wire logic [223:0] i_s_tdata,
    // [0] cmd
    input  wire logic [0:0]   i_s_tuser,
    // result words
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [1:0] status, [7:2] slot
    output logic [7:0]        o_m_tdata
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam logic [SLOT_W:0]   SIZE_EXT = (SLOT_W+1)'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [KEY_W-1:0]  KEY_MASK = {KEY_W{1'b1}} >> (8 * (8 - LOGIN_CHARS));

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_QUOT  = 3'd2;
    localparam logic [2:0] S_REM   = 3'd3;
    localparam logic [2:0] S_HOME  = 3'd4;
    localparam logic [2:0] S_PROBE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [SLOT_W-1:0]   r_step, n_step;
    logic [SLOT_W-1:0]   r_cnt, n_cnt;
    logic                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [DH_W-1:0]     r_dh;
    logic [DM_W-1:0]     r_dm;
    logic [DL_W-1:0]     r_dl;
    logic [SUM_W-1:0]    r_sum;
    logic [7:0]          r_quot;
    logic [3:0]          r_rem;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;

    logic [KEY_W-1:0]    key_trim;
    logic [SUM_W-1:0]    byte_sum;
    logic [SUM_W+RECIP10_W-1:0] quot_prod;
    logic [SUM_W-1:0]    rem_full;
    logic [SLOT_W-1:0]   home;
    logic [SLOT_W:0]     pos_sum, step_sum;
    logic [SLOT_W-1:0]   pos_adv, step_adv;
    logic                in_acc;
    logic                out_load;
    logic [SLOT_W+SLOT_OUT_W-1:0] res_slot_ext;

    logic                ram_we;
    t_entry              wr_entry, rd_entry;
    logic [ENTRY_W-1:0]  rd_data;

    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    // Trim key and add its bytes
    assign key_trim = i_s_tdata[KEY_W-1:0] & KEY_MASK;
    always_comb begin
        byte_sum = '0;
        for (int b = 0; b < 8; b++) begin
            byte_sum = byte_sum + SUM_W'(key_trim[8*b +: 8]);
        end
    end

    // Sum divided by ten and its remainder
    assign quot_prod = {{RECIP10_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, RECIP10};
    assign rem_full  = r_sum - ({r_quot, 3'b000} + {2'b00, r_quot, 1'b0});

    // Home slot: TABLE_SIZE * ((7 * rem) mod 10) / 10
    always_comb begin
        unique case (r_rem)
            4'd0:    home = '0;
            4'd1:    home = SLOT_W'((TABLE_SIZE * 7) / 10);
            4'd2:    home = SLOT_W'((TABLE_SIZE * 4) / 10);
            4'd3:    home = SLOT_W'((TABLE_SIZE * 1) / 10);
            4'd4:    home = SLOT_W'((TABLE_SIZE * 8) / 10);
            4'd5:    home = SLOT_W'((TABLE_SIZE * 5) / 10);
            4'd6:    home = SLOT_W'((TABLE_SIZE * 2) / 10);
            4'd7:    home = SLOT_W'((TABLE_SIZE * 9) / 10);
            4'd8:    home = SLOT_W'((TABLE_SIZE * 6) / 10);
            4'd9:    home = SLOT_W'((TABLE_SIZE * 3) / 10);
            default: home = '0;
        endcase
    end

    // Advance probe position by the next odd step, modulo the table size
    assign pos_sum  = {1'b0, r_pos} + {1'b0, r_step};
    assign pos_adv  = (pos_sum >= SIZE_EXT) ? SLOT_W'(pos_sum - SIZE_EXT)
                                            : pos_sum[SLOT_W-1:0];
    assign step_sum = {1'b0, r_step} + (SLOT_W+1)'(2);
    assign step_adv = (step_sum >= SIZE_EXT) ? SLOT_W'(step_sum - SIZE_EXT)
                                             : step_sum[SLOT_W-1:0];

    assign rd_entry = t_entry'(rd_data);

    // Entry to write: cleared during the reset pass, filled on register
    always_comb begin
        wr_entry.used        = (r_state == S_PROBE);
        wr_entry.digest_low  = r_dl;
        wr_entry.digest_mid  = r_dm;
        wr_entry.digest_high = r_dh;
        wr_entry.login       = r_key;
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_step       = r_step;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        ram_we       = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_pos  = r_pos + SLOT_W'(1);
                if (r_pos == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                n_state = S_REM;
            end
            S_REM: begin
                n_state = S_HOME;
            end
            S_HOME: begin
                n_pos   = home;
                n_step  = SLOT_W'(1);
                n_cnt   = '0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (r_cmd == CMD_REGISTER) begin
                    if (!rd_entry.used) begin
                        ram_we       = 1'b1;
                        n_res_status = ST_STORED;
                        n_res_slot   = r_pos;
                        n_state      = S_DONE;
                    end else if (r_cnt == LAST_IDX) begin
                        n_res_status = ST_FULL;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_pos  = pos_adv;
                        n_step = step_adv;
                        n_cnt  = r_cnt + SLOT_W'(1);
                    end
                end else begin
                    if (!rd_entry.used) begin
                        n_res_status = ST_REJECT;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else if (rd_entry.login == r_key) begin
                        if (rd_entry.digest_high == r_dh && rd_entry.digest_mid == r_dm &&
                            rd_entry.digest_low == r_dl) begin
                            n_res_status = ST_ACCEPT;
                            n_res_slot   = r_pos;
                        end else begin
                            n_res_status = ST_REJECT;
                            n_res_slot   = '0;
                        end
                        n_state = S_DONE;
                    end else if (r_cnt == LAST_IDX) begin
                        n_res_status = ST_REJECT;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_pos  = pos_adv;
                        n_step = step_adv;
                        n_cnt  = r_cnt + SLOT_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        if (in_acc) begin
            r_cmd <= i_s_tuser[0];
            r_key <= key_trim;
            r_dh  <= i_s_tdata[KEY_W +: DH_W];
            r_dm  <= i_s_tdata[KEY_W+DH_W +: DM_W];
            r_dl  <= i_s_tdata[KEY_W+DH_W+DM_W +: DL_W];
            r_sum <= byte_sum;
        end
        if (r_state == S_QUOT) begin
            r_quot <= quot_prod[RECIP10_SHIFT +: 8];
        end
        if (r_state == S_REM) begin
            r_rem <= rem_full[3:0];
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= res_slot_ext[SLOT_OUT_W-1:0];
        end
    end

    assign res_slot_ext = {{SLOT_OUT_W{1'b0}}, r_res_slot};

    // Slot store; read address follows the next probe position
    qpct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE),
        .ADDR_W(SLOT_W)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_pos),
        .i_wdata(wr_entry),
        .i_raddr(n_pos),
        .o_rdata(rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_slot, r_out_status};

endmodule : quadratic_probe_credential_table_top
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadratic-probe credential table. Input words
// (register or check commands) go in through the slave stream in bursts with
// random gaps. Result words are taken under a rotating stall pattern and
// compared, field by field, with a table model kept inside a scoreboard
// class. Directed words cover home-slot collisions, duplicates, digest
// mismatches and a full probe chain. Random traffic then mixes fresh logins
// with replays of enrolled credentials.
// ----------------------------------------------------------------------------
module testbench;
    import qpct_pkg::*;

    localparam int TABLE_SIZE  = TABLE_SIZE_DEF;
    localparam int LOGIN_CHARS = LOGIN_CHARS_DEF;
    localparam int RANDOM_WORDS = 1630;

    typedef struct {
        logic [KEY_W-1:0] login;
        logic [DH_W-1:0]  dh;
        logic [DM_W-1:0]  dm;
        logic [DL_W-1:0]  dl;
    } t_credential;

    // Table model plus the queue of result words still owed by the block
    class t_credential_scoreboard;
        bit               used[TABLE_SIZE];
        logic [KEY_W-1:0] login[TABLE_SIZE];
        logic [DH_W-1:0]  dh[TABLE_SIZE];
        logic [DM_W-1:0]  dm[TABLE_SIZE];
        logic [DL_W-1:0]  dl[TABLE_SIZE];
        logic [7:0]       expected_replies[$];
        int               fail_count;

        function new();
            fail_count = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        // Drop key bytes past LOGIN_CHARS
        function logic [KEY_W-1:0] trim_login(logic [KEY_W-1:0] key);
            logic [KEY_W-1:0] kept;
            kept = '0;
            for (int b = 0; b < LOGIN_CHARS && b < 8; b++) kept[8*b +: 8] = key[8*b +: 8];
            return kept;
        endfunction

        // Home slot from the byte sum, fraction of 0.7*sum taken in tenths
        function int home_of(logic [KEY_W-1:0] key);
            int sum;
            sum = 0;
            for (int b = 0; b < 8; b++) sum += key[8*b +: 8];
            return (TABLE_SIZE * ((7 * sum) % 10)) / 10;
        endfunction

        // Apply one accepted input word to the model and queue its result
        function void note_request(logic cmd, t_credential c);
            logic [KEY_W-1:0]    key;
            logic [STATUS_W-1:0] status;
            logic [5:0]          slot;
            int                  home;
            int                  s;
            bit                  done;
            key  = trim_login(c.login);
            home = home_of(key);
            slot = '0;
            done = 1'b0;
            if (cmd == CMD_REGISTER) begin
                status = ST_FULL;
                for (int i = 0; i < TABLE_SIZE && !done; i++) begin
                    s = (home + i * i) % TABLE_SIZE;
                    if (!used[s]) begin
                        used[s]  = 1'b1;
                        login[s] = key;
                        dh[s]    = c.dh;
                        dm[s]    = c.dm;
                        dl[s]    = c.dl;
                        status   = ST_STORED;
                        slot     = 6'(s);
                        done     = 1'b1;
                    end
                end
            end else begin
                status = ST_REJECT;
                for (int i = 0; i < TABLE_SIZE && !done; i++) begin
                    s = (home + i * i) % TABLE_SIZE;
                    if (!used[s]) begin
                        done = 1'b1;
                    end else if (login[s] == key) begin
                        if (dh[s] == c.dh && dm[s] == c.dm && dl[s] == c.dl) begin
                            status = ST_ACCEPT;
                            slot   = 6'(s);
                        end
                        done = 1'b1;
                    end
                end
            end
            expected_replies.push_back({slot, status});
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_reply(logic [7:0] word);
            logic [7:0] want;
            if (expected_replies.size() == 0) begin
                $error("result word %h arrived with nothing expected", word);
                fail_count++;
                return;
            end
            want = expected_replies.pop_front();
            if (word[1:0] !== want[1:0]) begin
                $error("status: expected %0d, got %0d", want[1:0], word[1:0]);
                fail_count++;
            end
            if (word[7:2] !== want[7:2]) begin
                $error("slot: expected %0d, got %0d", want[7:2], word[7:2]);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    wire logic    o_s_tready;
    // [63:0] login_key, [127:64] digest_high, [191:128] digest_mid,
    // [223:192] digest_low
    logic [223:0] i_s_tdata = '0;
    // [0] cmd
    logic [0:0]   i_s_tuser = '0;
    wire logic    o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // [1:0] status, [7:2] slot
    wire logic [7:0] o_m_tdata;

    t_credential_scoreboard board;
    t_credential            enrolled[$];
    int                     burst_left = 0;

    quadratic_probe_credential_table_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_credential make_cred(logic [KEY_W-1:0] key, logic [DH_W-1:0] h,
                                              logic [DM_W-1:0] m, logic [DL_W-1:0] l);
        t_credential c;
        c.login = key;
        c.dh    = h;
        c.dm    = m;
        c.dl    = l;
        return c;
    endfunction

    // Random login, often with some bytes zeroed
    function automatic logic [KEY_W-1:0] random_login();
        logic [KEY_W-1:0] k;
        logic [7:0]       keep;
        k    = {$urandom, $urandom};
        keep = 8'($urandom);
        if ($urandom_range(1) == 1) begin
            for (int b = 0; b < 8; b++) if (!keep[b]) k[8*b +: 8] = 8'h00;
        end
        return k;
    endfunction

    function automatic t_credential random_cred();
        return make_cred(random_login(), {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    endfunction

    // Login whose byte sum is a multiple of ten: home slot 0, byte moved around
    function automatic logic [KEY_W-1:0] home_zero_login(int n);
        return 64'(10 * n) << (8 * (n % 8));
    endfunction

    // Present one word, hold it until accepted, then maybe open a gap
    task automatic send_word(input logic cmd, input t_credential c);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {c.dl, c.dm, c.dh, c.login};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(cmd, c);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Edge cases: extremes, collisions on home 0, duplicates, full chain
    task automatic run_directed();
        t_credential zero_c;
        t_credential ones_c;
        t_credential dup_c;
        t_credential c;
        zero_c = make_cred('0, '0, '0, '0);
        ones_c = make_cred('1, '1, '1, '1);
        dup_c  = make_cred('0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        send_word(CMD_REGISTER, zero_c);
        send_word(CMD_REGISTER, ones_c);
        send_word(CMD_CHECK, zero_c);
        send_word(CMD_CHECK, ones_c);
        c = zero_c;
        c.dl = 32'h1;
        send_word(CMD_CHECK, c);
        c = ones_c;
        c.dh[63] = 1'b0;
        send_word(CMD_CHECK, c);
        // duplicate login lands further down the chain, first copy wins
        send_word(CMD_REGISTER, dup_c);
        send_word(CMD_CHECK, dup_c);
        // unknown login with a free home slot
        send_word(CMD_CHECK, make_cred(64'h1, '0, '0, '0));
        // fill every slot reachable from home 0, then one more
        for (int n = 1; n <= 10; n++)
            send_word(CMD_REGISTER, make_cred(home_zero_login(n), 64'(n), 64'(n), 32'(n)));
        // absent login walks the whole probe sequence without a free slot
        send_word(CMD_CHECK, make_cred(home_zero_login(10), 64'd10, 64'd10, 32'd10));
        send_word(CMD_CHECK, make_cred(home_zero_login(5), 64'd5, 64'd5, 32'd5));
    endtask

    // Mostly replays of enrolled credentials, some fresh logins and noise
    task automatic run_random(input int count);
        t_credential c;
        int          pick;
        int          variant;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                c = random_cred();
                if (enrolled.size() > 0 && $urandom_range(6) == 0)
                    c.login = enrolled[$urandom_range(enrolled.size() - 1)].login;
                enrolled.push_back(c);
                send_word(CMD_REGISTER, c);
            end else if (pick < 88 && enrolled.size() > 0) begin
                c = enrolled[$urandom_range(enrolled.size() - 1)];
                variant = $urandom_range(9);
                case (variant)
                    6: c.dh ^= 64'd1 << $urandom_range(63);
                    7: c.dm ^= 64'd1 << $urandom_range(63);
                    8: c.dl ^= 32'd1 << $urandom_range(31);
                    9: c.login ^= 64'd1 << $urandom_range(63);
                    default: ;
                endcase
                send_word(CMD_CHECK, c);
            end else begin
                send_word(CMD_CHECK, random_cred());
            end
        end
    endtask

    // Result side: accept under a rotating ready pattern, reshuffled now and then
    initial begin : reply_sink
        logic [15:0] pattern;
        int          phase;
        pattern = '1;
        phase   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) board.check_reply(o_m_tdata);
            phase++;
            if (phase % 300 == 0) begin
                case ($urandom_range(3))
                    0: pattern = '1;
                    1: pattern = 16'($urandom) | 16'($urandom);
                    default: pattern = 16'($urandom);
                endcase
                if (pattern == '0) pattern = 16'h0001;
            end
            pattern = {pattern[14:0], pattern[15]};
            i_m_tready <= pattern[0];
        end
    end

    // Main sequence
    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(RANDOM_WORDS);
        i_s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (board.fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: reports a mismatch and stops the run if it hangs
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : testbench
`default_nettype wire
